@@ hw/rtl/lrucm_pkg.sv @@
// Shared types and constants of the LRU cache miss classifier.
// Used by the result and configuration interfaces and by every module of the block; depends on nothing.
package lrucm_pkg;

    // Field and register widths
    localparam int ACTIVE_W   = 7;
    localparam int LSIZE_W    = 4;
    localparam int CLS_W      = 3;
    localparam int KEY_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LINES   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_SIZE_LOG2 = 1'd1;

    // Register reset values and line size clamp range
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;
    localparam logic [LSIZE_W-1:0]  LSIZE_RESET  = 4'd6;
    localparam logic [LSIZE_W-1:0]  LSIZE_MIN    = 4'd4;
    localparam logic [LSIZE_W-1:0]  LSIZE_MAX    = 4'd12;

    // Input action codes
    localparam logic ACTION_ACCESS = 1'b0;
    localparam logic ACTION_FLUSH  = 1'b1;

    // Result classes
    localparam logic [CLS_W-1:0] CLS_READ_HIT          = 3'd0;
    localparam logic [CLS_W-1:0] CLS_WRITE_HIT         = 3'd1;
    localparam logic [CLS_W-1:0] CLS_READ_CAPACITY     = 3'd2;
    localparam logic [CLS_W-1:0] CLS_WRITE_CAPACITY    = 3'd3;
    localparam logic [CLS_W-1:0] CLS_READ_COMPULSORY   = 3'd4;
    localparam logic [CLS_W-1:0] CLS_WRITE_COMPULSORY  = 3'd5;

    // Seen-line map: 64 bits per memory row, 1024 rows
    localparam int SEEN_BIT_W    = 6;
    localparam int SEEN_ROW_BITS = 1 << SEEN_BIT_W;
    localparam int SEEN_ADDR_W   = KEY_W - SEEN_BIT_W;
    localparam int SEEN_ROWS     = 1 << SEEN_ADDR_W;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                   capture;   // access transfer: latch key, read seen row
        logic                   look;      // tag compare, seen row write-back
        logic                   update;    // cache update and result load
        logic                   clear;     // clearing pass cycle
        logic [SEEN_ADDR_W-1:0] clear_row; // seen row cleared this cycle
    } cmd_t;

endpackage

@@ hw/rtl/lrucm_item_if.sv @@
// Input channel of the classifier: one access or flush per transfer.
// Depends on nothing.
interface lrucm_item_if #(
    parameter int ADDR_BITS = 20
);
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [ADDR_BITS-1:0] address;
    logic                 is_read;

    modport source (output valid, action, address, is_read, input ready);
    modport sink   (input valid, action, address, is_read, output ready);
endinterface

@@ hw/rtl/lrucm_result_if.sv @@
// Result channel of the classifier: one access class per transfer.
// Depends on lrucm_pkg.
interface lrucm_result_if;
    logic                         valid;
    logic                         ready;
    logic [lrucm_pkg::CLS_W-1:0]  access_class;

    modport source (output valid, access_class, input ready);
    modport sink   (input valid, access_class, output ready);
endinterface

@@ hw/rtl/lrucm_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on lrucm_pkg.
interface lrucm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lrucm_pkg::CFG_IDX_W-1:0]  index;
    logic [lrucm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/lrucm_cfg.sv @@
// Configuration registers with clamping of out-of-range values.
// Depends on lrucm_pkg.
module lrucm_cfg #(
    parameter int NUM_LINES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_valid,
    output logic                                wr_ready,
    input  logic [lrucm_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [lrucm_pkg::CFG_DATA_W-1:0]    wr_data,
    output logic [$clog2(NUM_LINES + 1)-1:0]    eff_active,
    output logic [lrucm_pkg::LSIZE_W-1:0]       eff_shift
);

    localparam int OCC_W = $clog2(NUM_LINES + 1);

    logic [lrucm_pkg::ACTIVE_W-1:0] active_reg, active_next;
    logic [lrucm_pkg::LSIZE_W-1:0]  lsize_reg, lsize_next;
    logic                           wr_fire;

    // Writes are always taken
    assign wr_ready = 1'b1;
    assign wr_fire  = wr_valid && wr_ready;

    // Register write decode
    always_comb
    begin
        active_next = active_reg;
        lsize_next  = lsize_reg;
        if (wr_fire) begin
            case (wr_index)
                lrucm_pkg::REG_ACTIVE_LINES:
                    active_next = wr_data[lrucm_pkg::ACTIVE_W-1:0];
                lrucm_pkg::REG_LINE_SIZE_LOG2:
                    lsize_next = wr_data[lrucm_pkg::LSIZE_W-1:0];
                default:
                begin
                    active_next = active_reg;
                    lsize_next  = lsize_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg <= lrucm_pkg::ACTIVE_RESET;
            lsize_reg  <= lrucm_pkg::LSIZE_RESET;
        end else begin
            active_reg <= active_next;
            lsize_reg  <= lsize_next;
        end
    end

    // Clamp active lines to 1..NUM_LINES
    always_comb
    begin
        if (active_reg == '0)
            eff_active = OCC_W'(1);
        else if (32'(active_reg) > 32'(NUM_LINES))
            eff_active = OCC_W'(NUM_LINES);
        else
            eff_active = OCC_W'(active_reg);
    end

    // Clamp line size to the supported range
    always_comb
    begin
        if (lsize_reg < lrucm_pkg::LSIZE_MIN)
            eff_shift = lrucm_pkg::LSIZE_MIN;
        else if (lsize_reg > lrucm_pkg::LSIZE_MAX)
            eff_shift = lrucm_pkg::LSIZE_MAX;
        else
            eff_shift = lsize_reg;
    end

endmodule

@@ hw/rtl/lrucm_ctrl.sv @@
// Controller: sequences clearing pass, lookup and update, owns result valid.
// Depends on lrucm_pkg (cmd_t, action codes, seen map size).
module lrucm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_action,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output lrucm_pkg::cmd_t   cmd
);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_LOOK   = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    localparam int ROW_W = lrucm_pkg::SEEN_ADDR_W;

    logic [1:0]       state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             accept;

    // Result slot can be loaded when empty or being taken
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) || ((state_reg == S_UPDATE) && out_free);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        cmd           = '0;
        cmd.clear_row = row_reg;
        cmd.capture   = accept && (in_action == lrucm_pkg::ACTION_ACCESS);
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                row_next  = row_reg + ROW_W'(1);
                if (row_reg == ROW_W'(lrucm_pkg::SEEN_ROWS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                    state_next = (in_action == lrucm_pkg::ACTION_FLUSH) ? S_CLEAR : S_LOOK;
            end
            S_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (out_free) begin
                    cmd.update = 1'b1;
                    if (!accept)
                        state_next = S_IDLE;
                    else if (in_action == lrucm_pkg::ACTION_FLUSH)
                        state_next = S_CLEAR;
                    else
                        state_next = S_LOOK;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Result valid: set on load, dropped when taken
    always_comb
    begin
        if (cmd.update)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_CLEAR;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Lookup always moves on to update
    a_look_then_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK) |=> (state_reg == S_UPDATE))
        else $error("lookup not followed by update");

    // Every update presents a result
    a_update_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> out_valid_reg)
        else $error("update without result");

endmodule

@@ hw/rtl/lrucm_dp.sv @@
// Datapath: line cells (tag, valid, rank), seen-line map memory, result register.
// Depends on lrucm_pkg (cmd_t, widths, class codes).
module lrucm_dp #(
    parameter int NUM_LINES = 64,
    parameter int ADDR_BITS = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lrucm_pkg::cmd_t                   cmd,
    input  logic [ADDR_BITS-1:0]              in_address,
    input  logic                              in_is_read,
    input  logic [$clog2(NUM_LINES + 1)-1:0]  eff_active,
    input  logic [lrucm_pkg::LSIZE_W-1:0]     eff_shift,
    output logic [lrucm_pkg::CLS_W-1:0]       out_class
);

    localparam int OCC_W  = $clog2(NUM_LINES + 1);
    localparam int RANK_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int KEY_W  = lrucm_pkg::KEY_W;
    localparam int BIT_W  = lrucm_pkg::SEEN_BIT_W;
    localparam int ROW_B  = lrucm_pkg::SEEN_ROW_BITS;

    logic [KEY_W-1:0]   key_comb, key_reg;
    logic               is_read_reg;

    logic [ROW_B-1:0]   seen_mem [lrucm_pkg::SEEN_ROWS];
    logic [ROW_B-1:0]   row_data_reg;
    logic [ROW_B-1:0]   set_mask;

    logic               valid_reg  [NUM_LINES];
    logic               valid_next [NUM_LINES];
    logic [RANK_W-1:0]  rank_reg   [NUM_LINES];
    logic [RANK_W-1:0]  rank_next  [NUM_LINES];
    logic [KEY_W-1:0]   tag_reg    [NUM_LINES];
    logic [KEY_W-1:0]   tag_next   [NUM_LINES];

    logic [NUM_LINES-1:0] match_comb, victim_comb, match_reg, victim_reg, slot_sel;
    logic [RANK_W-1:0]    hit_rank_comb, hit_rank_reg;
    logic                 hit_reg, seen_reg, evict_reg;
    logic                 miss;
    logic [OCC_W-1:0]     occ_reg, occ_next;
    logic [lrucm_pkg::CLS_W-1:0] class_reg, class_next;

    // Line number of the incoming address
    assign key_comb = KEY_W'(32'(in_address) >> eff_shift);

    always_ff @(posedge clk)
    begin
        if (cmd.capture) begin
            key_reg     <= key_comb;
            is_read_reg <= in_is_read;
        end
    end

    // Seen-line map: row read on capture, bit set on lookup, rows zeroed on clear
    assign set_mask = ROW_B'(1) << key_reg[BIT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
            seen_mem[cmd.clear_row] <= '0;
        else if (cmd.look)
            seen_mem[key_reg[KEY_W-1:BIT_W]] <= row_data_reg | set_mask;
        if (cmd.capture)
            row_data_reg <= seen_mem[key_comb[KEY_W-1:BIT_W]];
    end

    // Per-line tag match and LRU victim flags, rank of the hit line
    always_comb
    begin
        hit_rank_comb = '0;
        for (int i = 0; i < NUM_LINES; i++) begin
            match_comb[i]  = valid_reg[i] && (tag_reg[i] == key_reg);
            victim_comb[i] = valid_reg[i] && (OCC_W'(rank_reg[i]) == (occ_reg - OCC_W'(1)));
            hit_rank_comb  = hit_rank_comb | (match_comb[i] ? rank_reg[i] : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.look) begin
            match_reg    <= match_comb;
            victim_reg   <= victim_comb;
            hit_rank_reg <= hit_rank_comb;
            hit_reg      <= |match_comb;
            seen_reg     <= row_data_reg[key_reg[BIT_W-1:0]];
            evict_reg    <= (occ_reg >= eff_active);
        end
    end

    // Miss fills the victim line when full, else the first free line
    assign miss = !seen_reg || !hit_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_LINES; i++)
            slot_sel[i] = evict_reg ? victim_reg[i] : (occ_reg == OCC_W'(i));
    end

    // Line cell update
    always_comb
    begin
        for (int i = 0; i < NUM_LINES; i++) begin
            valid_next[i] = valid_reg[i];
            rank_next[i]  = rank_reg[i];
            tag_next[i]   = tag_reg[i];
            if (cmd.clear) begin
                valid_next[i] = 1'b0;
                rank_next[i]  = '0;
            end else if (cmd.update) begin
                if (miss) begin
                    if (slot_sel[i]) begin
                        valid_next[i] = 1'b1;
                        tag_next[i]   = key_reg;
                        rank_next[i]  = '0;
                    end else if (valid_reg[i]) begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end else begin
                    if (match_reg[i])
                        rank_next[i] = '0;
                    else if (valid_reg[i] && (rank_reg[i] < hit_rank_reg))
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
        end
    end

    // Occupancy grows only on a miss that does not evict
    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.clear)
            occ_next = '0;
        else if (cmd.update && miss && !evict_reg)
            occ_next = occ_reg + OCC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            occ_reg <= '0;
            for (int i = 0; i < NUM_LINES; i++) begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
        end else begin
            occ_reg <= occ_next;
            for (int i = 0; i < NUM_LINES; i++) begin
                valid_reg[i] <= valid_next[i];
                rank_reg[i]  <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_LINES; i++)
            tag_reg[i] <= tag_next[i];
    end

    // Result class
    always_comb
    begin
        if (!seen_reg)
            class_next = is_read_reg ? lrucm_pkg::CLS_READ_COMPULSORY
                                     : lrucm_pkg::CLS_WRITE_COMPULSORY;
        else if (hit_reg)
            class_next = is_read_reg ? lrucm_pkg::CLS_READ_HIT : lrucm_pkg::CLS_WRITE_HIT;
        else
            class_next = is_read_reg ? lrucm_pkg::CLS_READ_CAPACITY
                                     : lrucm_pkg::CLS_WRITE_CAPACITY;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
            class_reg <= class_next;
    end

    assign out_class = class_reg;

    // A hit finds exactly one resident copy of the line
    a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && !miss) |-> $onehot(match_reg))
        else $error("hit without a unique matching line");

    // An evicting miss has exactly one least recent line
    a_victim_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && miss && evict_reg) |-> $onehot(victim_reg))
        else $error("eviction without a unique victim");

    // An unseen line is never resident
    a_unseen_not_resident: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && !seen_reg) |-> !hit_reg)
        else $error("unseen line found resident");

endmodule

@@ hw/rtl/lru_cache_miss_classifier.sv @@
// Top level of the LRU cache miss classifier.
// Depends on lrucm_pkg, the three channel interfaces, lrucm_cfg, lrucm_ctrl, lrucm_dp.
//
// Usage:
//   item   : one transfer per access or flush (action, address, is_read).
//   result : one access_class per access; a flush gives no result.
//   cfg    : register writes (active_lines, line_size_log2), always ready;
//            write only while the block is idle.
// Result path: the access transfer, then the lookup state, then the update state,
//   which loads the output register once the result slot is free. Accesses are
//   paced by the seen-line map read-modify-write (row read at transfer, tag
//   compare and write-back in the next cycle, line update and result load in the
//   update state, overlapped with the next transfer).
// Reset and flush: a clearing pass zeroes all 1024 rows of the seen-line map,
//   one 64-bit row per cycle, while item is not ready; line valid bits and
//   occupancy clear at once. A flush transfer starts the same pass.
// Receiver stall: a finished result waits in the output register; the next
//   access is still taken, and its update waits until the slot frees.
module lru_cache_miss_classifier #(
    parameter int NUM_LINES = 64,
    parameter int ADDR_BITS = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    lrucm_item_if.sink        item,
    lrucm_result_if.source    result,
    lrucm_cfg_if.sink         cfg
);

    localparam int OCC_W = $clog2(NUM_LINES + 1);

    lrucm_pkg::cmd_t              cmd;
    logic [OCC_W-1:0]             eff_active;
    logic [lrucm_pkg::LSIZE_W-1:0] eff_shift;

    // Configuration registers
    lrucm_cfg #(
        .NUM_LINES (NUM_LINES)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_valid   (cfg.valid),
        .wr_ready   (cfg.ready),
        .wr_index   (cfg.index),
        .wr_data    (cfg.data),
        .eff_active (eff_active),
        .eff_shift  (eff_shift)
    );

    // Sequencer
    lrucm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_action (item.action),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // Line cells, seen map and result register
    lrucm_dp #(
        .NUM_LINES (NUM_LINES),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_address (item.address),
        .in_is_read (item.is_read),
        .eff_active (eff_active),
        .eff_shift  (eff_shift),
        .out_class  (result.access_class)
    );

endmodule
